FILE: sv/rrcb_pkg.sv
// Shared types, widths and helper functions for the rounded-rect coverage blender.
// No dependencies; imported by every module of the block.
package rrcb_pkg;

  localparam int COORD_W   = 13;
  localparam int FRAC_W    = 4;
  localparam int RAD_W     = 16;
  localparam int COLOR_W   = 24;
  localparam int ALPHA_W   = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 24;

  localparam int DIFF_W = COORD_W + 1;
  localparam int HALF_W = COORD_W + FRAC_W - 1;
  localparam int CMP_W  = (RAD_W > HALF_W) ? RAD_W : HALF_W;
  localparam int OFF_W  = COORD_W + FRAC_W + 2;
  localparam int MAG_W  = OFF_W - 1;
  localparam int K_W    = OFF_W + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = SQ_W + 1;
  localparam int SQRT_N = (SUM_W + 1) / 2;
  localparam int NPAD_W = 2 * SQRT_N;
  localparam int REM_W  = SQRT_N + 3;
  localparam int DIST_W = K_W + 4;
  localparam int COV_W  = 9;
  localparam int WGT_W  = 17;
  localparam int MAG_CH_W = 24;

  localparam int Q_DEPTH = 8;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  localparam int LEN_HALF = 1 << (FRAC_W - 1);
  localparam int LEN_ONE  = 1 << FRAC_W;
  localparam int COV_ONE  = 256;
  localparam logic [RAD_W-1:0] SOLID_MARK = '1;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT, REG_TOP, REG_RIGHT, REG_BOTTOM,
    REG_RADIUS, REG_THICK, REG_COLOUR, REG_ALPHA
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] bottom;
    logic [RAD_W-1:0]          radius;
    logic [RAD_W-1:0]          thick;
    logic [COLOR_W-1:0]        colour;
    logic [ALPHA_W-1:0]        alpha;
  } cfg_t;

  // classified pixel handed from front to back
  typedef struct packed {
    logic [COLOR_W-1:0]    dest;
    logic                  empty;
    logic [MAG_W-1:0]      ax;
    logic [MAG_W-1:0]      ay;
    logic signed [K_W-1:0] k;     // min(max(dx,dy),0) - r
  } item_t;

  typedef struct packed {
    logic [COLOR_W-1:0]    dest;
    logic                  empty;
    logic signed [K_W-1:0] k;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [SQRT_N-1:0] root;
    logic [NPAD_W-1:0] n;
  } sq_t;

  // one digit of a restoring square root
  function automatic sq_t sqrt_step(sq_t s);
    sq_t              o;
    logic [REM_W-1:0] rs;
    logic [REM_W-1:0] trial;
    rs    = {s.rem[REM_W-3:0], s.n[NPAD_W-1 -: 2]};
    trial = REM_W'({s.root, 2'b01});
    if (rs >= trial) begin
      o.rem  = rs - trial;
      o.root = {s.root[SQRT_N-2:0], 1'b1};
    end else begin
      o.rem  = rs;
      o.root = {s.root[SQRT_N-2:0], 1'b0};
    end
    o.n = {s.n[NPAD_W-3:0], 2'b00};
    return o;
  endfunction

  // clamp(1/2 - d, 0, 1) in 1/256 units
  function automatic logic [COV_W-1:0] cover_of(logic signed [DIST_W-1:0] d);
    logic signed [DIST_W:0] t;
    logic [COV_W-1:0]       c;
    t = (DIST_W+1)'(LEN_HALF) - (DIST_W+1)'(d);
    if (t <= 0) begin
      c = '0;
    end else if (t >= LEN_ONE) begin
      c = COV_W'(COV_ONE);
    end else begin
      c = COV_W'(t[FRAC_W-1:0]) << (8 - FRAC_W);
    end
    return c;
  endfunction

endpackage

FILE: sv/rrcb_front.sv
// Front end: accepts pixels and classifies them against the rectangle geometry.
// Depends on rrcb_pkg.
module rrcb_front import rrcb_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic signed [COORD_W-1:0] pixel_x_i,
  input  logic signed [COORD_W-1:0] pixel_y_i,
  input  logic [COLOR_W-1:0]        dest_pixel_i,
  input  cfg_t                      cfg_i,
  output logic                      valid_o,
  output item_t                     item_o
);

  logic v0_q, v1_q, v2_q;

  // stage 0
  logic signed [DIFF_W-1:0] xl_q, yt_q, w_q, h_q;
  logic [COLOR_W-1:0]       dest0_q;
  // stage 1
  logic [MAG_W-1:0]  aox_q, aoy_q;
  logic [RAD_W-1:0]  r_q;
  logic [HALF_W-1:0] w8_q, h8_q;
  logic              empty1_q;
  logic [COLOR_W-1:0] dest1_q;
  // stage 2
  item_t item_q;

  logic signed [DIFF_W-1:0] mn_wh;
  logic [HALF_W-1:0]        half_d, w8_d, h8_d;
  logic [RAD_W-1:0]         r_d;
  logic signed [OFF_W-1:0]  ox, oy;
  logic                     empty_d;

  always_comb begin
    empty_d = (w_q <= 0) || (h_q <= 0);
    mn_wh   = (w_q < h_q) ? w_q : h_q;
    half_d  = HALF_W'({mn_wh[DIFF_W-2:0], {(FRAC_W-1){1'b0}}});
    w8_d    = HALF_W'({w_q[DIFF_W-2:0], {(FRAC_W-1){1'b0}}});
    h8_d    = HALF_W'({h_q[DIFF_W-2:0], {(FRAC_W-1){1'b0}}});
    r_d     = (CMP_W'(cfg_i.radius) < CMP_W'(half_d)) ? cfg_i.radius : RAD_W'(half_d);
    ox = OFF_W'(signed'({xl_q, {FRAC_W{1'b0}}})) + OFF_W'(LEN_HALF)
       - OFF_W'(signed'({w_q, {(FRAC_W-1){1'b0}}}));
    oy = OFF_W'(signed'({yt_q, {FRAC_W{1'b0}}})) + OFF_W'(LEN_HALF)
       - OFF_W'(signed'({h_q, {(FRAC_W-1){1'b0}}}));
  end

  logic [CMP_W-1:0]        hx, hy;
  logic signed [OFF_W-1:0] dx, dy, mx, mn;
  item_t                   item_d;

  always_comb begin
    hx = CMP_W'(w8_q) - CMP_W'(r_q);
    hy = CMP_W'(h8_q) - CMP_W'(r_q);
    dx = $signed({1'b0, aox_q}) - OFF_W'($signed({1'b0, hx}));
    dy = $signed({1'b0, aoy_q}) - OFF_W'($signed({1'b0, hy}));
    mx = (dx > dy) ? dx : dy;
    mn = (mx > 0) ? '0 : mx;
    item_d.dest  = dest1_q;
    item_d.empty = empty1_q;
    item_d.ax    = (dx > 0) ? dx[MAG_W-1:0] : '0;
    item_d.ay    = (dy > 0) ? dy[MAG_W-1:0] : '0;
    item_d.k     = K_W'(mn) - K_W'($signed({1'b0, r_q}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    xl_q    <= DIFF_W'(pixel_x_i) - DIFF_W'(cfg_i.left);
    yt_q    <= DIFF_W'(pixel_y_i) - DIFF_W'(cfg_i.top);
    w_q     <= DIFF_W'(cfg_i.right) - DIFF_W'(cfg_i.left);
    h_q     <= DIFF_W'(cfg_i.bottom) - DIFF_W'(cfg_i.top);
    dest0_q <= dest_pixel_i;

    aox_q    <= ox[OFF_W-1] ? MAG_W'(-ox) : ox[MAG_W-1:0];
    aoy_q    <= oy[OFF_W-1] ? MAG_W'(-oy) : oy[MAG_W-1:0];
    r_q      <= r_d;
    w8_q     <= w8_d;
    h8_q     <= h8_d;
    empty1_q <= empty_d;
    dest1_q  <= dest0_q;

    item_q <= item_d;
  end

  assign valid_o = v2_q;
  assign item_o  = item_q;

endmodule

FILE: sv/rrcb_queue.sv
// Short queue between front and back ends; head entry read from flops.
// Depends on rrcb_pkg.
module rrcb_queue import rrcb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t head_o
);

  item_t             mem_q [Q_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> cnt_q != QCNT_W'(Q_DEPTH))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("queue underflow");

endmodule

FILE: sv/rrcb_back.sv
// Back end: squares, pipelined square root, coverage and per-channel blend.
// Depends on rrcb_pkg; the last stage is the output register.
module rrcb_back import rrcb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               valid_i,
  input  item_t              item_i,
  output logic               take_o,
  output logic               valid_o,
  output logic [COLOR_W-1:0] result_pixel_o,
  output logic               touched_o,
  input  logic               pop_i
);

  logic adv;

  logic              v0_q;
  logic [SQ_W-1:0]   sqx_q, sqy_q;
  side_t             side0_q;

  logic [SQRT_N:0]   vs_q;
  sq_t               sq_q   [SQRT_N+1];
  side_t             side_q [SQRT_N+1];

  logic               vc_q, tc_q;
  logic [WGT_W-1:0]   wgt_q;
  logic [COLOR_W-1:0] dc_q;

  logic                vm_q, tm_q, pass_q, full_q;
  logic [2:0]          ge_q;
  logic [MAG_CH_W-1:0] mag_q [3];
  logic [COLOR_W-1:0]  dm_q;

  logic               vo_q, to_q;
  logic [COLOR_W-1:0] res_q;

  assign adv    = !vo_q || pop_i;
  assign take_o = adv && valid_i;

  // coverage stage
  side_t                   last;
  logic [SQRT_N:0]         s;
  logic signed [DIST_W-1:0] sdist, dist_in;
  logic [COV_W-1:0]        outer, inner, cov;
  logic [ALPHA_W-1:0]      alpha_s;
  logic [WGT_W-1:0]        wgt_d;
  logic                    touch_d;

  always_comb begin
    last    = side_q[SQRT_N];
    s       = (SQRT_N+1)'(sq_q[SQRT_N].root)
            + (SQRT_N+1)'(sq_q[SQRT_N].rem > REM_W'(sq_q[SQRT_N].root));
    sdist   = DIST_W'($signed({1'b0, s})) + DIST_W'(last.k);
    dist_in = sdist + DIST_W'($signed({1'b0, cfg_i.thick}));
    outer   = cover_of(sdist);
    inner   = (cfg_i.thick == SOLID_MARK) ? '0 : cover_of(dist_in);
    cov     = outer - inner;
    touch_d = !last.empty && (cov != '0);
    alpha_s = (cfg_i.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg_i.alpha;
    wgt_d   = WGT_W'(cov) * WGT_W'(alpha_s);
  end

  // multiply stage
  logic [2:0]          ge_d;
  logic [MAG_CH_W-1:0] mag_d [3];
  logic [7:0]          pd, pp, diff;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pd       = dc_q[8*c +: 8];
      pp       = cfg_i.colour[8*c +: 8];
      ge_d[c]  = (pp >= pd);
      diff     = ge_d[c] ? (pp - pd) : (pd - pp);
      mag_d[c] = MAG_CH_W'(diff) * MAG_CH_W'(wgt_q[WGT_W-2:0]);
    end
  end

  // final stage: round half away from zero and clamp
  logic [COLOR_W-1:0]  res_d;
  logic [MAG_CH_W:0]   rnd;
  logic [8:0]          q, sum;
  logic [7:0]          dd;

  always_comb begin
    res_d = dm_q;
    rnd   = '0;
    q     = '0;
    sum   = '0;
    dd    = '0;
    if (!pass_q) begin
      if (full_q) begin
        res_d = cfg_i.colour;
      end else begin
        for (int c = 0; c < 3; c++) begin
          dd  = dm_q[8*c +: 8];
          rnd = (MAG_CH_W+1)'(mag_q[c]) + (MAG_CH_W+1)'(32768);
          q   = 9'(rnd >> 16);
          sum = 9'(dd) + q;
          if (ge_q[c]) begin
            res_d[8*c +: 8] = sum[8] ? 8'hff : sum[7:0];
          end else begin
            res_d[8*c +: 8] = (q > 9'(dd)) ? 8'h00 : 8'(9'(dd) - q);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      vs_q <= '0;
      vc_q <= 1'b0;
      vm_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v0_q <= valid_i;
      vs_q <= {vs_q[SQRT_N-1:0], v0_q};
      vc_q <= vs_q[SQRT_N];
      vm_q <= vc_q;
      vo_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqx_q   <= SQ_W'(item_i.ax) * SQ_W'(item_i.ax);
      sqy_q   <= SQ_W'(item_i.ay) * SQ_W'(item_i.ay);
      side0_q <= '{dest: item_i.dest, empty: item_i.empty, k: item_i.k};

      sq_q[0]   <= '{rem: '0, root: '0, n: NPAD_W'(SUM_W'(sqx_q) + SUM_W'(sqy_q))};
      side_q[0] <= side0_q;
      for (int i = 1; i <= SQRT_N; i++) begin
        sq_q[i]   <= sqrt_step(sq_q[i-1]);
        side_q[i] <= side_q[i-1];
      end

      wgt_q <= wgt_d;
      tc_q  <= touch_d;
      dc_q  <= last.dest;

      for (int c = 0; c < 3; c++) mag_q[c] <= mag_d[c];
      ge_q   <= ge_d;
      tm_q   <= tc_q;
      pass_q <= !tc_q || (wgt_q == '0);
      full_q <= wgt_q[WGT_W-1];
      dm_q   <= dc_q;

      res_q <= res_d;
      to_q  <= tm_q;
    end
  end

  assign valid_o        = vo_q;
  assign result_pixel_o = res_q;
  assign touched_o      = to_q;

endmodule

FILE: sv/rounded_rect_coverage_blend_unit.sv
// Top level of the rounded-rect coverage blender: config registers, credit
// counter, front end, queue and back end. Depends on rrcb_pkg and all rrcb_ modules.
//
// Usage:
//   Input side is a queue: drive pixel_x_i, pixel_y_i, dest_pixel_i with
//   push_i; a word is taken on a clock edge where push_i is high and full_o
//   is low. Output side is a queue too: while empty_o is low the oldest
//   result sits on result_pixel_o / touched_o and is taken when pop_i is high.
//   One result word per input word, in order.
//   Throughput: one pixel per clock while the consumer keeps popping.
//   The back end holds a 19-stage square root pipeline.
//   Config: cfg_we_i writes cfg_data_i into register cfg_idx_i at the clock
//   edge, no wait; write only while no pixel is in flight.
//   Reset (rst_ni low, async) empties all pipelines and the queue and loads
//   the register defaults: empty rectangle, solid fill, opaque black.
//   When pop_i stays low while a result waits, the back end holds its whole
//   pipeline; the front end keeps draining into the queue, and full_o rises
//   once the credits covering front end plus queue are used up.
module rounded_rect_coverage_blend_unit import rrcb_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  output logic                      full_o,
  input  logic signed [COORD_W-1:0] pixel_x_i,
  input  logic signed [COORD_W-1:0] pixel_y_i,
  input  logic [COLOR_W-1:0]        dest_pixel_i,
  output logic                      empty_o,
  input  logic                      pop_i,
  output logic [COLOR_W-1:0]        result_pixel_o,
  output logic                      touched_o,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_W-1:0]          cfg_data_i
);

  cfg_t cfg_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left   <= '0;
      cfg_q.top    <= '0;
      cfg_q.right  <= '0;
      cfg_q.bottom <= '0;
      cfg_q.radius <= '0;
      cfg_q.thick  <= SOLID_MARK;
      cfg_q.colour <= '0;
      cfg_q.alpha  <= ALPHA_ONE;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_LEFT:   cfg_q.left   <= cfg_data_i[COORD_W-1:0];
        REG_TOP:    cfg_q.top    <= cfg_data_i[COORD_W-1:0];
        REG_RIGHT:  cfg_q.right  <= cfg_data_i[COORD_W-1:0];
        REG_BOTTOM: cfg_q.bottom <= cfg_data_i[COORD_W-1:0];
        REG_RADIUS: cfg_q.radius <= cfg_data_i[RAD_W-1:0];
        REG_THICK:  cfg_q.thick  <= cfg_data_i[RAD_W-1:0];
        REG_COLOUR: cfg_q.colour <= cfg_data_i[COLOR_W-1:0];
        REG_ALPHA:  cfg_q.alpha  <= cfg_data_i[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // credits: words in the front end plus words held in the queue
  logic              accept, fr_valid, q_valid, q_take;
  logic [QCNT_W-1:0] cnt_q;
  item_t             fr_item, q_head;

  assign full_o = (cnt_q == QCNT_W'(Q_DEPTH));
  assign accept = push_i && !full_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + QCNT_W'(accept) - QCNT_W'(q_take);
    end
  end

  rrcb_front u_front (
    .clk_i,
    .rst_ni,
    .valid_i      (accept),
    .pixel_x_i,
    .pixel_y_i,
    .dest_pixel_i,
    .cfg_i        (cfg_q),
    .valid_o      (fr_valid),
    .item_o       (fr_item)
  );

  rrcb_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (fr_valid),
    .data_i  (fr_item),
    .pop_i   (q_take),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  logic out_valid;

  rrcb_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i          (cfg_q),
    .valid_i        (q_valid),
    .item_i         (q_head),
    .take_o         (q_take),
    .valid_o        (out_valid),
    .result_pixel_o,
    .touched_o,
    .pop_i
  );

  assign empty_o = !out_valid;

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(Q_DEPTH))
    else $error("credit count above queue depth");

  a_no_credit_no_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> !q_valid && !fr_valid)
    else $error("queue or front end busy with no credit outstanding");

endmodule

FILE: tb/sv/rounded_rect_coverage_blend_unit_tb.sv
// Testbench for rounded_rect_coverage_blend_unit: directed table plus random pixels,
// checked against an in-bench coverage/blend predictor. Depends on rrcb_pkg and the RTL.
module rounded_rect_coverage_blend_unit_tb;
  import rrcb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 2_000_000;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      push_i = 1'b0;
  logic                      full_o;
  logic signed [COORD_W-1:0] pixel_x_i = '0;
  logic signed [COORD_W-1:0] pixel_y_i = '0;
  logic [COLOR_W-1:0]        dest_pixel_i = '0;
  logic                      empty_o;
  logic                      pop_i = 1'b0;
  logic [COLOR_W-1:0]        result_pixel_o;
  logic                      touched_o;
  logic                      cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_idx_i = '0;
  logic [CFG_W-1:0]          cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  rounded_rect_coverage_blend_unit dut (.*);

  // shadow copy of the register file
  cfg_t shadow;

  typedef struct {
    logic [COLOR_W-1:0] pix;
    logic               hit;
  } blend_t;

  blend_t pending_px[$];
  int     n_err = 0, n_words = 0, n_hits = 0, n_phases = 0;
  int     cycles = 0;
  bit     hold_pop = 0;   // long receiver stall request

  // ---- predictor -------------------------------------------------------
  function automatic longint isqrt_near(longint unsigned n);
    longint unsigned r = 0, b;
    // plain integer search, then round to nearest
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    begin
      longint unsigned rem = n;
      while (b != 0) begin
        if (rem >= r + b) begin
          rem -= r + b;
          r = (r >> 1) + b;
        end else r >>= 1;
        b >>= 2;
      end
    end
    if (n > r * r + r) r++;
    return longint'(r);
  endfunction

  function automatic int cov_at(longint d);
    longint t = LEN_HALF - d;
    if (t <= 0) return 0;
    if (t >= LEN_ONE) return 256;
    return int'(t) << (8 - FRAC_W);
  endfunction

  function automatic int mix8(int dst, int src, int wgt);
    longint q;
    if (src >= dst) begin
      q = (longint'(src - dst) * wgt + 32768) >>> 16;
      return (dst + q > 255) ? 255 : dst + int'(q);
    end
    q = (longint'(dst - src) * wgt + 32768) >>> 16;
    return (q > dst) ? 0 : dst - int'(q);
  endfunction

  function automatic blend_t coverage_blend(int x, int y, logic [COLOR_W-1:0] dst);
    blend_t o;
    longint l, t, w, h, r, lim, ox, oy, dx, dy, ax, ay, mn, sdist;
    int cov, al, wgt;
    o.pix = dst; o.hit = 0;
    l = shadow.left; t = shadow.top;
    w = longint'(shadow.right) - l;
    h = longint'(shadow.bottom) - t;
    if (w <= 0 || h <= 0) return o;
    r = shadow.radius;
    lim = ((w < h) ? w : h) * LEN_HALF;
    if (r > lim) r = lim;
    ox = (x - l) * LEN_ONE + LEN_HALF - w * LEN_HALF;
    oy = (y - t) * LEN_ONE + LEN_HALF - h * LEN_HALF;
    if (ox < 0) ox = -ox;
    if (oy < 0) oy = -oy;
    dx = ox - (w * LEN_HALF - r);
    dy = oy - (h * LEN_HALF - r);
    ax = dx > 0 ? dx : 0;
    ay = dy > 0 ? dy : 0;
    mn = dx > dy ? dx : dy;
    if (mn > 0) mn = 0;
    sdist = isqrt_near(ax * ax + ay * ay) + mn - r;
    cov = cov_at(sdist);
    if (shadow.thick != SOLID_MARK) cov -= cov_at(sdist + shadow.thick);
    if (cov == 0) return o;
    o.hit = 1;
    al = (shadow.alpha > 256) ? 256 : int'(shadow.alpha);
    wgt = cov * al;
    if (wgt == 0) return o;
    if (wgt >= 65536) begin
      o.pix = shadow.colour;
      return o;
    end
    o.pix = {8'(mix8(dst[23:16], shadow.colour[23:16], wgt)),
             8'(mix8(dst[15:8], shadow.colour[15:8], wgt)),
             8'(mix8(dst[7:0], shadow.colour[7:0], wgt))};
    return o;
  endfunction

  // ---- config (only while idle) ----------------------------------------
  task automatic write_reg(cfg_reg_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_W'(val);
    case (idx)
      REG_LEFT:   shadow.left   = COORD_W'(val);
      REG_TOP:    shadow.top    = COORD_W'(val);
      REG_RIGHT:  shadow.right  = COORD_W'(val);
      REG_BOTTOM: shadow.bottom = COORD_W'(val);
      REG_RADIUS: shadow.radius = RAD_W'(val);
      REG_THICK:  shadow.thick  = RAD_W'(val);
      REG_COLOUR: shadow.colour = COLOR_W'(val);
      default:    shadow.alpha  = ALPHA_W'(val);
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_rect(int l, int t, int r, int b, int rad, int th, int col, int al);
    write_reg(REG_LEFT, l);   write_reg(REG_TOP, t);
    write_reg(REG_RIGHT, r);  write_reg(REG_BOTTOM, b);
    write_reg(REG_RADIUS, rad); write_reg(REG_THICK, th);
    write_reg(REG_COLOUR, col); write_reg(REG_ALPHA, al);
    n_phases++;
  endtask

  // wait until every expected word came back, plus pipeline slack
  task automatic drain();
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // ---- sender ----------------------------------------------------------
  task automatic idle_gap();
    int g = $urandom_range(0, 99);
    if (g < 55) return;
    push_i <= 1'b0;
    repeat ((g < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk_i);
  endtask

  // one word offered; returns once accepted. If gap is off, push stays high.
  task automatic send_px(int x, int y, int unsigned d, bit gaps,
                         bit known = 0, blend_t want = '{0, 0});
    blend_t p;
    if (gaps) idle_gap();
    push_i       <= 1'b1;
    pixel_x_i    <= COORD_W'(x);
    pixel_y_i    <= COORD_W'(y);
    dest_pixel_i <= COLOR_W'(d);
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    // signed views of the driven coordinates
    p = coverage_blend($signed(COORD_W'(x)), $signed(COORD_W'(y)), COLOR_W'(d));
    if (known && (p.pix !== want.pix || p.hit !== want.hit)) begin
      $error("table row disagrees with predictor at x=%0d y=%0d", x, y);
      n_err++;
    end
    pending_px.push_back(known ? want : p);
  endtask

  // ---- receiver --------------------------------------------------------
  int pop_hold;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_i <= 1'b0;
      pop_hold = 0;
    end else begin
      if (pop_i && !empty_o) begin
        blend_t e;
        if (pending_px.size() == 0) begin
          $error("result word with nothing expected");
          n_err++;
        end else begin
          e = pending_px.pop_front();
          if (result_pixel_o !== e.pix) begin
            $error("result_pixel exp %06h got %06h", e.pix, result_pixel_o);
            n_err++;
          end
          if (touched_o !== e.hit) begin
            $error("touched exp %0b got %0b", e.hit, touched_o);
            n_err++;
          end
          n_words++;
          if (e.hit) n_hits++;
        end
      end
      if (hold_pop) pop_i <= 1'b0;
      else if (pop_hold > 0) begin
        pop_hold--;
        pop_i <= 1'b0;
      end else begin
        int g;
        g = $urandom_range(0, 99);
        if (g < 15) pop_hold = $urandom_range(1, 3);
        else if (g < 17) pop_hold = $urandom_range(10, 40);
        pop_i <= (g >= 17);
      end
    end
  end

  // ---- watchdog --------------------------------------------------------
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("rounded_rect_coverage_blend_unit_tb: done, errors");
      $finish;
    end
  end

  // ---- directed table --------------------------------------------------
  typedef struct {
    int x, y;
    int unsigned d;
    bit known;
    int unsigned pix;
    bit hit;
  } row_t;

  row_t rows[$];

  task automatic run_rows(bit gaps);
    foreach (rows[i])
      send_px(rows[i].x, rows[i].y, rows[i].d, gaps, rows[i].known,
              '{COLOR_W'(rows[i].pix), rows[i].hit});
    push_i <= 1'b0;
    rows.delete();
  endtask

  task automatic rand_px(int l, int t, int r, int b, bit gaps);
    int x, y;
    // mostly near the rectangle so edges and corners get exercised
    if ($urandom_range(0, 9) < 8) begin
      x = $urandom_range(0, r - l + 8) + l - 4;
      y = $urandom_range(0, b - t + 8) + t - 4;
      if (x > 4095) x = 4095;
      if (y > 4095) y = 4095;
    end else begin
      x = $urandom_range(0, 8191) - 4096;
      y = $urandom_range(0, 8191) - 4096;
    end
    send_px(x, y, $urandom(), gaps);
  endtask

  initial begin
    int l, t, r, b, rad, th;
    shadow = '{left: 0, top: 0, right: 0, bottom: 0, radius: 0,
               thick: SOLID_MARK, colour: 0, alpha: ALPHA_ONE};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // after reset: empty rectangle, everything passes through untouched
    rows.push_back('{-4096, -4096, 24'hFFFFFF, 1, 24'hFFFFFF, 0});
    rows.push_back('{4095, 4095, 24'h000000, 1, 24'h000000, 0});
    rows.push_back('{0, 0, 24'h123456, 1, 24'h123456, 0});
    run_rows(0);
    drain();

    // solid opaque box: interior gets the paint colour, outside unchanged
    set_rect(10, 20, 30, 40, 0, 65535, 24'hA5C3F0, 256);
    rows.push_back('{15, 25, 24'h000000, 1, 24'hA5C3F0, 1});
    rows.push_back('{10, 20, 24'h111111, 1, 24'hA5C3F0, 1});
    rows.push_back('{29, 39, 24'h111111, 1, 24'hA5C3F0, 1});
    rows.push_back('{30, 25, 24'h777777, 1, 24'h777777, 0});
    rows.push_back('{9, 25, 24'h777777, 1, 24'h777777, 0});
    rows.push_back('{-4096, 4095, 24'hFFFFFF, 1, 24'hFFFFFF, 0});
    run_rows(0);
    drain();

    // huge radius (clamped), half alpha, thin ring
    set_rect(-8, -8, 8, 4, 65535, 20, 24'hFFFFFF, 128);
    for (int i = -9; i <= 8; i++) rows.push_back('{i, i / 2, 24'h000000, 0, 0, 0});
    run_rows(0);
    drain();

    // zero alpha: touched but colour kept; alpha above 256 saturates
    set_rect(0, 0, 5, 5, 8, 65535, 24'hFF0000, 0);
    rows.push_back('{2, 2, 24'h00FF00, 1, 24'h00FF00, 1});
    run_rows(0);
    drain();
    write_reg(REG_ALPHA, 511);
    rows.push_back('{2, 2, 24'h00FF00, 1, 24'hFF0000, 1});
    rows.push_back('{0, 0, 24'h00FF00, 0, 0, 0});
    run_rows(0);
    drain();
    // inverted rectangle: empty
    set_rect(4095, 100, -4096, 200, 0, 0, 24'hFFFFFF, 256);
    rows.push_back('{0, 150, 24'h00FF00, 1, 24'h00FF00, 0});
    run_rows(0);
    drain();

    // random phases with new registers each time
    for (int ph = 0; ph < 16; ph++) begin
      l = $urandom_range(0, 8191) - 4096;
      t = $urandom_range(0, 8191) - 4096;
      r = l + $urandom_range(1, 40);
      b = t + $urandom_range(1, 40);
      if (ph == 3) begin l = -4096; t = -4096; r = 4095; b = 4095; end
      if (r > 4095) r = 4095;
      if (b > 4095) b = 4095;
      rad = ($urandom_range(0, 3) == 0) ? $urandom() & 16'hFFFF : $urandom_range(0, 400);
      th = ($urandom_range(0, 2) == 0) ? 65535 :
           ($urandom_range(0, 3) == 0) ? $urandom() & 16'hFFFF : $urandom_range(0, 40);
      set_rect(l, t, r, b, rad, th, $urandom() & 24'hFFFFFF, $urandom_range(0, 511));
      if (ph == 5) begin
        // receiver stalls long while sender keeps pushing
        hold_pop = 1;
        fork
          begin repeat (300) @(posedge clk_i); hold_pop = 0; end
          for (int i = 0; i < 60; i++) rand_px(l, t, r, b, 0);
        join
      end
      for (int i = 0; i < 100; i++) rand_px(l, t, r, b, ph % 4 != 1);
      push_i <= 1'b0;
      drain();   // sender waits for every result
    end
    drain();

    $display("covered %0d words (%0d blended) over %0d register settings",
             n_words, n_hits, n_phases);
    if (n_err == 0 && pending_px.size() == 0)
      $display("rounded_rect_coverage_blend_unit_tb: done, clean");
    else
      $display("rounded_rect_coverage_blend_unit_tb: done, errors");
    $finish;
  end

endmodule

FILE: files.f
sv/rrcb_pkg.sv
sv/rrcb_front.sv
sv/rrcb_queue.sv
sv/rrcb_back.sv
sv/rounded_rect_coverage_blend_unit.sv
tb/sv/rounded_rect_coverage_blend_unit_tb.sv
